// ===== hw/rtl/dtp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types and constants for the disparity to point reprojection block.
// ----------------------------------------------------------------------------
package dtp_pkg;

  // Pixel geometry
  localparam int unsigned MAX_DIM  = 4096;
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned DISP_W   = 16;

  // Quotient datapath: numerator is REM_W + WORD_W bits, divisor is REM_W bits
  localparam int unsigned REM_W     = 15;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_W     = REM_W + WORD_W;
  localparam int unsigned DIV_STEPS = WORD_W;

  // Lanes of the shared-divisor pipeline
  localparam int unsigned LANES  = 3;
  localparam int unsigned LANE_X = 0;
  localparam int unsigned LANE_Y = 1;
  localparam int unsigned LANE_Z = 2;

  // Register reset values
  localparam logic        [23:0] FOCAL_RST    = 24'd287853;
  localparam logic signed [23:0] BASELINE_RST = -24'sd6874;
  localparam logic        [15:0] CENTER_X_RST = 16'd16160;
  localparam logic        [15:0] CENTER_Y_RST = 16'd12352;
  localparam logic        [30:0] DEPTH_MIN_RST = 31'd32768;
  localparam logic        [30:0] DEPTH_MAX_RST = 31'd78643;

  typedef enum logic [2:0] {
    REG_FOCAL     = 3'd0,
    REG_BASELINE  = 3'd1,
    REG_CENTER_X  = 3'd2,
    REG_CENTER_Y  = 3'd3,
    REG_DEPTH_MIN = 3'd4,
    REG_DEPTH_MAX = 3'd5
  } dtp_reg_e;

  // Partial remainder plus the numerator bits still to shift in; the low
  // end fills up with quotient bits as the steps go.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [WORD_W-1:0] word;
  } dtp_lane_t;

  // Sideband that rides along with the quotient
  typedef struct packed {
    logic [LANES-1:0]   neg;
    logic [LANES-1:0]   ovf;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } dtp_tag_t;

endpackage

// ===== hw/rtl/dtp_divider.sv =====
// ----------------------------------------------------------------------------
// dtp_divider
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor. Global enable freezes every stage.
// ----------------------------------------------------------------------------
module dtp_divider (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic [dtp_pkg::REM_W-1:0]               divisor_i,
  input  dtp_pkg::dtp_lane_t [dtp_pkg::LANES-1:0] lane_i,
  input  dtp_pkg::dtp_tag_t                       tag_i,
  output logic                                    valid_o,
  output dtp_pkg::dtp_lane_t [dtp_pkg::LANES-1:0] lane_o,
  output dtp_pkg::dtp_tag_t                       tag_o
);
  import dtp_pkg::*;

  function automatic dtp_lane_t div_step(dtp_lane_t cur, logic [REM_W-1:0] dsr);
    logic [REM_W:0] shifted;
    logic [REM_W:0] diff;
    logic           ge;
    dtp_lane_t      nxt;
    shifted  = {cur.rem, cur.word[WORD_W-1]};
    diff     = shifted - {1'b0, dsr};
    ge       = (shifted >= {1'b0, dsr});
    nxt.rem  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    nxt.word = {cur.word[WORD_W-2:0], ge};
    return nxt;
  endfunction

  logic      [DIV_STEPS-1:0] vld_q;
  dtp_lane_t [LANES-1:0]     lane_q [DIV_STEPS];
  logic      [REM_W-1:0]     dsr_q  [DIV_STEPS];
  dtp_tag_t                  tag_q  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic                  vld_in;
    dtp_lane_t [LANES-1:0] lane_in;
    dtp_lane_t [LANES-1:0] lane_d;
    logic [REM_W-1:0]      dsr_in;
    dtp_tag_t              tag_in;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign lane_in = lane_i;
      assign dsr_in  = divisor_i;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign lane_in = lane_q[k-1];
      assign dsr_in  = dsr_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        lane_d[l] = div_step(lane_in[l], dsr_in);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lane_q[k] <= lane_d;
        dsr_q[k]  <= dsr_in;
        tag_q[k]  <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign lane_o  = lane_q[DIV_STEPS-1];
  assign tag_o   = tag_q[DIV_STEPS-1];

endmodule

// ===== hw/rtl/disparity_to_point_reprojection.sv =====
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection
// Turns a stereo disparity pixel into a Q16.16 point (X, Y, Z), kept only
// when Z lies inside the configured depth window.
// ----------------------------------------------------------------------------
//  channel   dir  words                       notes
//  s_axis    in   disparity, column, row      one pixel per word
//  m_axis    out  point_x/y/z, column, row    zero or one word per pixel
//  apb       in   six 32-bit registers        write only while idle
//
//  One pixel per clock sustained while the skid entry is empty. m_axis_tvalid
//  rises once a pixel has passed the three setup stages (offset, multiply,
//  magnitude; the first loads on the accepting edge), the 32-stage
//  one-bit-per-stage quotient pipeline and then the output register.
//  Reset clears all valid bits and loads the register defaults.
//  A waiting result sits in the output register with one skid entry behind
//  it; the pipeline freezes and s_axis_tready drops only once the skid fills.
// ----------------------------------------------------------------------------
module disparity_to_point_reprojection (
  input  logic         clk_i,
  input  logic         rst_ni,
  // disparity [15:0], column [27:16], row [39:28]
  input  logic [39:0]  s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_x [31:0], point_y [63:32], point_z [94:64], out_column [106:95],
  // out_row [118:107], zero [119]
  output logic [119:0] m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import dtp_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        [23:0] focal_q;
  logic signed [23:0] baseline_q;
  logic        [15:0] center_x_q;
  logic        [15:0] center_y_q;
  logic        [30:0] depth_min_q;
  logic        [30:0] depth_max_q;
  logic               cfg_we;
  dtp_reg_e           reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign reg_idx = dtp_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q     <= FOCAL_RST;
      baseline_q  <= BASELINE_RST;
      center_x_q  <= CENTER_X_RST;
      center_y_q  <= CENTER_Y_RST;
      depth_min_q <= DEPTH_MIN_RST;
      depth_max_q <= DEPTH_MAX_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_FOCAL:     focal_q     <= pwdata[23:0];
        REG_BASELINE:  baseline_q  <= $signed(pwdata[23:0]);
        REG_CENTER_X:  center_x_q  <= pwdata[15:0];
        REG_CENTER_Y:  center_y_q  <= pwdata[15:0];
        REG_DEPTH_MIN: depth_min_q <= pwdata[30:0];
        REG_DEPTH_MAX: depth_max_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FOCAL:     prdata = {8'd0, focal_q};
      REG_BASELINE:  prdata = {8'd0, baseline_q};
      REG_CENTER_X:  prdata = {16'd0, center_x_q};
      REG_CENTER_Y:  prdata = {16'd0, center_y_q};
      REG_DEPTH_MIN: prdata = {1'b0, depth_min_q};
      REG_DEPTH_MAX: prdata = {1'b0, depth_max_q};
      default:       prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline enable: everything advances unless the skid entry is occupied
  // --------------------------------------------------------------------------
  logic skid_vld_q, skid_vld_d;
  logic out_vld_q,  out_vld_d;
  logic en;

  assign en            = ~skid_vld_q;
  assign s_axis_tready = en;

  // --------------------------------------------------------------------------
  // Stage 1: unpack, range checks, pixel offsets from the principal point
  // --------------------------------------------------------------------------
  logic [DISP_W-1:0]  in_disp;
  logic [COORD_W-1:0] in_col;
  logic [COORD_W-1:0] in_row;
  logic               in_keep;

  assign in_disp = s_axis_tdata[15:0];
  assign in_col  = s_axis_tdata[27:16];
  assign in_row  = s_axis_tdata[39:28];
  // positive disparity and pixel inside the image
  assign in_keep = ~in_disp[DISP_W-1] & (|in_disp[DISP_W-2:0])
                 & ({5'd0, in_col} < 17'(MAX_DIM))
                 & ({5'd0, in_row} < 17'(MAX_DIM));

  logic                     v1_q;
  logic [REM_W-1:0]         d1_q;
  logic [COORD_W-1:0]       col1_q, row1_q;
  logic signed [16:0]       dx1_q,  dy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid & in_keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q   <= in_disp[REM_W-1:0];
      col1_q <= in_col;
      row1_q <= in_row;
      dx1_q  <= $signed({1'b0, in_col, 4'd0} - {1'b0, center_x_q});
      dy1_q  <= $signed({1'b0, in_row, 4'd0} - {1'b0, center_y_q});
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: products f*b, b*dx, b*dy
  // --------------------------------------------------------------------------
  logic signed [48:0] prod_z;
  logic signed [40:0] prod_x, prod_y;

  assign prod_z = $signed({1'b0, focal_q}) * baseline_q;
  assign prod_x = baseline_q * dx1_q;
  assign prod_y = baseline_q * dy1_q;

  logic               v2_q;
  logic [REM_W-1:0]   d2_q;
  logic [COORD_W-1:0] col2_q, row2_q;
  logic [47:0]        pz2_q;
  logic [40:0]        px2_q, py2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q   <= d1_q;
      col2_q <= col1_q;
      row2_q <= row1_q;
      pz2_q  <= prod_z[47:0];
      px2_q  <= prod_x;
      py2_q  <= prod_y;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: magnitudes, result signs, quotient overflow check
  // floor(|fb|/(16d)) = floor((|fb|>>4)/d), so every lane divides by d.
  // --------------------------------------------------------------------------
  logic [47:0]           mag_z;
  logic [40:0]           mag_x, mag_y;
  logic [NUM_W-1:0]      num [LANES];
  dtp_lane_t [LANES-1:0] lane3_d;
  dtp_tag_t              tag3_d;

  assign mag_z = pz2_q[47] ? (~pz2_q + 48'd1) : pz2_q;
  assign mag_x = px2_q[40] ? (~px2_q + 41'd1) : px2_q;
  assign mag_y = py2_q[40] ? (~py2_q + 41'd1) : py2_q;

  assign num[LANE_Z] = {4'd0, mag_z[46:4]};
  assign num[LANE_X] = {7'd0, mag_x[39:0]};
  assign num[LANE_Y] = {7'd0, mag_y[39:0]};

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane3_d[l].rem  = num[l][NUM_W-1:WORD_W];
      lane3_d[l].word = num[l][WORD_W-1:0];
      tag3_d.ovf[l]   = (num[l][NUM_W-1:WORD_W] >= d2_q);
    end
    // the result is the negated quotient: positive product, negative point
    tag3_d.neg[LANE_Z] = ~pz2_q[47];
    tag3_d.neg[LANE_X] = ~px2_q[40];
    tag3_d.neg[LANE_Y] = ~py2_q[40];
    tag3_d.col         = col2_q;
    tag3_d.row         = row2_q;
  end

  logic                  v3_q;
  logic [REM_W-1:0]      d3_q;
  dtp_lane_t [LANES-1:0] lane3_q;
  dtp_tag_t              tag3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q    <= d2_q;
      lane3_q <= lane3_d;
      tag3_q  <= tag3_d;
    end
  end

  // --------------------------------------------------------------------------
  // Quotient pipeline
  // --------------------------------------------------------------------------
  logic                  div_vld;
  dtp_lane_t [LANES-1:0] div_lane;
  dtp_tag_t              div_tag;

  dtp_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v3_q),
    .divisor_i (d3_q),
    .lane_i    (lane3_q),
    .tag_i     (tag3_q),
    .valid_o   (div_vld),
    .lane_o    (div_lane),
    .tag_o     (div_tag)
  );

  // --------------------------------------------------------------------------
  // Sign, saturation and depth window
  // --------------------------------------------------------------------------
  function automatic logic [31:0] sat_signed(logic [WORD_W-1:0] q, logic ovf, logic neg);
    logic big;
    big = ovf | q[WORD_W-1];
    if (neg) begin
      return big ? 32'h8000_0000 : (~q + 32'd1);
    end
    return big ? 32'h7FFF_FFFF : q;
  endfunction

  logic [31:0]  pt_x, pt_y, pt_z;
  logic         win_ok;
  logic         take;
  logic [119:0] cand;

  assign pt_x = sat_signed(div_lane[LANE_X].word, div_tag.ovf[LANE_X], div_tag.neg[LANE_X]);
  assign pt_y = sat_signed(div_lane[LANE_Y].word, div_tag.ovf[LANE_Y], div_tag.neg[LANE_Y]);
  assign pt_z = sat_signed(div_lane[LANE_Z].word, div_tag.ovf[LANE_Z], div_tag.neg[LANE_Z]);

  assign win_ok = ~pt_z[31] & (pt_z[30:0] >= depth_min_q) & (pt_z[30:0] < depth_max_q);
  assign take   = div_vld & win_ok;
  assign cand   = {1'b0, div_tag.row, div_tag.col, pt_z[30:0], pt_y, pt_x};

  // --------------------------------------------------------------------------
  // Output register with one skid entry
  // --------------------------------------------------------------------------
  logic [119:0] out_q,  out_d;
  logic [119:0] skid_q, skid_d;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (m_axis_tready) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_d = take;
      out_d     = cand;
    end else if (take) begin
      skid_vld_d = 1'b1;
      skid_d     = cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
